@@ hdl/asg_pkg.sv @@
package asg_pkg;

	localparam int SENSOR_COUNT_DEF = 16;
	localparam int GAIN_LEVELS      = 4;

	localparam int SAMPLE_W  = 10;
	localparam int CHAN_W    = 3;
	localparam int GAIN_W    = 2;
	localparam int IRSEL_W   = 4;
	localparam int SCALE_W   = 8;
	localparam int CURRENT_W = 15;
	localparam int SWPOS_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 56;

	localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(GAIN_LEVELS - 1);

	// channel codes
	localparam logic [CHAN_W-1:0] CH_IR      = 3'd0;
	localparam logic [CHAN_W-1:0] CH_SWITCH  = 3'd1;
	localparam logic [CHAN_W-1:0] CH_RIGHT   = 3'd4;
	localparam logic [CHAN_W-1:0] CH_LEFT    = 3'd5;
	localparam logic [CHAN_W-1:0] CH_BATTERY = 3'd6;
	localparam logic [CHAN_W-1:0] CH_BOOST   = 3'd7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOOST     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SW_UPPER  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SW_LOWER  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd6;

	// register reset values
	localparam logic [SAMPLE_W-1:0] RST_GAIN_HIGH = 10'd900;
	localparam logic [SAMPLE_W-1:0] RST_GAIN_LOW  = 10'd175;
	localparam logic [SAMPLE_W-1:0] RST_BATTERY   = 10'd450;
	localparam logic [SAMPLE_W-1:0] RST_BOOST     = 10'd800;
	localparam logic [SAMPLE_W-1:0] RST_SW_UPPER  = 10'd768;
	localparam logic [SAMPLE_W-1:0] RST_SW_LOWER  = 10'd256;
	localparam logic [SCALE_W-1:0]  RST_SCALE     = 8'd147;

	localparam logic [SWPOS_W-1:0] SW_UP     = 2'd0;
	localparam logic [SWPOS_W-1:0] SW_MIDDLE = 2'd1;
	localparam logic [SWPOS_W-1:0] SW_DOWN   = 2'd2;

	typedef struct packed {
		logic [SAMPLE_W-1:0] gain_high;
		logic [SAMPLE_W-1:0] gain_low;
		logic [SAMPLE_W-1:0] battery;
		logic [SAMPLE_W-1:0] boost;
		logic [SAMPLE_W-1:0] sw_upper;
		logic [SAMPLE_W-1:0] sw_lower;
		logic [SCALE_W-1:0]  scale;
	} asg_cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0]    next_channel;
		logic [IRSEL_W-1:0]   ir_mux_select;
		logic [GAIN_W-1:0]    gain_select;
		logic                 ir_sample_valid;
		logic [IRSEL_W-1:0]   ir_index;
		logic                 frame_done;
		logic [GAIN_W-1:0]    frame_gain;
		logic                 battery_low;
		logic                 boost_ready;
		logic [SWPOS_W-1:0]   switch_pos;
		logic [CURRENT_W-1:0] left_current;
		logic [CURRENT_W-1:0] right_current;
	} asg_result_t;

endpackage

@@ hdl/asg_cfg.sv @@
module asg_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [asg_pkg::CFG_IDX_W-1:0]     index,
	input  logic [asg_pkg::CFG_DAT_W-1:0]     wdata,
	output asg_pkg::asg_cfg_t                 cfg
);

	asg_pkg::asg_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_high <= asg_pkg::RST_GAIN_HIGH;
			cfg_q.gain_low  <= asg_pkg::RST_GAIN_LOW;
			cfg_q.battery   <= asg_pkg::RST_BATTERY;
			cfg_q.boost     <= asg_pkg::RST_BOOST;
			cfg_q.sw_upper  <= asg_pkg::RST_SW_UPPER;
			cfg_q.sw_lower  <= asg_pkg::RST_SW_LOWER;
			cfg_q.scale     <= asg_pkg::RST_SCALE;
		end else if (wr_en) begin
			case (index)
				asg_pkg::REG_GAIN_HIGH: cfg_q.gain_high <= wdata[asg_pkg::SAMPLE_W-1:0];
				asg_pkg::REG_GAIN_LOW:  cfg_q.gain_low  <= wdata[asg_pkg::SAMPLE_W-1:0];
				asg_pkg::REG_BATTERY:   cfg_q.battery   <= wdata[asg_pkg::SAMPLE_W-1:0];
				asg_pkg::REG_BOOST:     cfg_q.boost     <= wdata[asg_pkg::SAMPLE_W-1:0];
				asg_pkg::REG_SW_UPPER:  cfg_q.sw_upper  <= wdata[asg_pkg::SAMPLE_W-1:0];
				asg_pkg::REG_SW_LOWER:  cfg_q.sw_lower  <= wdata[asg_pkg::SAMPLE_W-1:0];
				asg_pkg::REG_SCALE:     cfg_q.scale     <= wdata[asg_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/asg_core.sv @@
module asg_core #(
	parameter int SENSOR_COUNT = asg_pkg::SENSOR_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [asg_pkg::SAMPLE_W-1:0]   sample,
	input  asg_pkg::asg_cfg_t              cfg,
	output asg_pkg::asg_result_t           result
);

	localparam int CW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam logic [CW:0] COUNT_END = (CW+1)'(SENSOR_COUNT);

	logic [asg_pkg::CHAN_W-1:0]   channel_q, channel_n;
	logic [CW-1:0]                count_q, count_n;
	logic [asg_pkg::GAIN_W-1:0]   next_gain_q, next_gain_n;
	logic [asg_pkg::GAIN_W-1:0]   latched_gain_q, latched_gain_n;
	logic [asg_pkg::SAMPLE_W-1:0] peak_q, peak_n;
	logic [asg_pkg::SAMPLE_W-1:0] battery_q, battery_n;
	logic [asg_pkg::SAMPLE_W-1:0] boost_q, boost_n;
	logic [asg_pkg::SAMPLE_W-1:0] left_q, left_n;
	logic [asg_pkg::SAMPLE_W-1:0] right_q, right_n;
	logic [asg_pkg::SAMPLE_W-1:0] switch_q, switch_n;

	logic [CW:0]                  count_inc;
	logic [asg_pkg::SAMPLE_W-1:0] peak_upd;
	logic                         ir_valid, frame_done;
	logic [CW+3:0]                idx_ext, sel_ext;
	logic [asg_pkg::SAMPLE_W+asg_pkg::SCALE_W-1:0] left_prod, right_prod;
	logic [asg_pkg::SWPOS_W-1:0]  sw_pos;

	always_comb begin
		channel_n      = channel_q;
		count_n        = count_q;
		next_gain_n    = next_gain_q;
		latched_gain_n = latched_gain_q;
		peak_n         = peak_q;
		battery_n      = battery_q;
		boost_n        = boost_q;
		left_n         = left_q;
		right_n        = right_q;
		switch_n       = switch_q;
		ir_valid       = 1'b0;
		frame_done     = 1'b0;
		count_inc      = {1'b0, count_q} + (CW+1)'(1);
		peak_upd       = (sample > peak_q) ? sample : peak_q;
		case (channel_q)
			asg_pkg::CH_IR: begin
				ir_valid = 1'b1;
				if (count_inc >= COUNT_END) begin
					frame_done     = 1'b1;
					count_n        = '0;
					latched_gain_n = next_gain_q;
					if (peak_upd > cfg.gain_high) begin
						if (next_gain_q != '0)
							next_gain_n = next_gain_q - 2'd1;
					end else if (peak_upd < cfg.gain_low) begin
						if (next_gain_q < asg_pkg::GAIN_MAX)
							next_gain_n = next_gain_q + 2'd1;
					end
					peak_n    = '0;
					channel_n = asg_pkg::CH_BOOST;
				end else begin
					count_n   = count_inc[CW-1:0];
					peak_n    = peak_upd;
					channel_n = asg_pkg::CH_IR;
				end
			end
			asg_pkg::CH_SWITCH: begin
				switch_n  = sample;
				channel_n = asg_pkg::CH_IR;
			end
			asg_pkg::CH_RIGHT: begin
				right_n   = sample;
				channel_n = asg_pkg::CH_SWITCH;
			end
			asg_pkg::CH_LEFT: begin
				left_n    = sample;
				channel_n = asg_pkg::CH_RIGHT;
			end
			asg_pkg::CH_BATTERY: begin
				battery_n = sample;
				channel_n = asg_pkg::CH_LEFT;
			end
			asg_pkg::CH_BOOST: begin
				boost_n   = sample;
				channel_n = asg_pkg::CH_BATTERY;
			end
			default: channel_n = asg_pkg::CH_BOOST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q      <= asg_pkg::CH_BOOST;
			count_q        <= '0;
			next_gain_q    <= '0;
			latched_gain_q <= '0;
			peak_q         <= '0;
			battery_q      <= '0;
			boost_q        <= '0;
			left_q         <= '0;
			right_q        <= '0;
			switch_q       <= '0;
		end else if (accept) begin
			channel_q      <= channel_n;
			count_q        <= count_n;
			next_gain_q    <= next_gain_n;
			latched_gain_q <= latched_gain_n;
			peak_q         <= peak_n;
			battery_q      <= battery_n;
			boost_q        <= boost_n;
			left_q         <= left_n;
			right_q        <= right_n;
			switch_q       <= switch_n;
		end
	end

	// result fields from the updated state
	always_comb begin
		idx_ext    = {4'b0, count_q};
		sel_ext    = {4'b0, count_n};
		left_prod  = left_n * cfg.scale;
		right_prod = right_n * cfg.scale;
		if (switch_n > cfg.sw_upper)
			sw_pos = asg_pkg::SW_DOWN;
		else if (switch_n > cfg.sw_lower)
			sw_pos = asg_pkg::SW_MIDDLE;
		else
			sw_pos = asg_pkg::SW_UP;

		result.next_channel    = channel_n;
		result.ir_mux_select   = sel_ext[3:0];
		result.gain_select     = next_gain_n;
		result.ir_sample_valid = ir_valid;
		result.ir_index        = ir_valid ? idx_ext[3:0] : 4'd0;
		result.frame_done      = frame_done;
		result.frame_gain      = latched_gain_n;
		result.battery_low     = (battery_n < cfg.battery);
		result.boost_ready     = (boost_n > cfg.boost);
		result.switch_pos      = sw_pos;
		result.left_current    = left_prod[asg_pkg::SAMPLE_W+asg_pkg::SCALE_W-1:3];
		result.right_current   = right_prod[asg_pkg::SAMPLE_W+asg_pkg::SCALE_W-1:3];
	end

endmodule

@@ hdl/asg_out.sv @@
module asg_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  asg_pkg::asg_result_t  in_result,
	output logic                  out_valid,
	input  logic                  out_ready,
	output asg_pkg::asg_result_t  out_result
);

	logic                 valid_q;
	asg_pkg::asg_result_t result_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			result_q <= in_result;
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

@@ hdl/adc_scan_sequencer_autogain_unit.sv @@
// adc scan sequencer with ir autogain
// s_axis: one beat per adc conversion result, sample in s_tdata[9:0], the
//   conversion of the channel that the previous result named as next
// m_axis: one result beat per input beat, in order; tlast marks the beat
//   that closed an ir frame, tuser flags a beat that came from an ir sensor
// cfg port: write enable, index and data; write only while no beat is in
//   flight; thresholds and motor current scale
// a result is on m_axis in the cycle after its input beat is taken
// throughput: one beat per cycle when not stalled; state update, threshold
//   compares and the two 10x8 current multipliers all sit between the state
//   registers and the single result register
// s_tready is low only while the result register is full and m_tready is
//   low; a stalled result holds until taken, with one more input beat
//   taken in the cycle it leaves
// reset: channel 7 (boost) first, sensor count, gains, frame peak and all
//   stored readings cleared, registers back to their defaults, no result
module adc_scan_sequencer_autogain_unit #(
	parameter int SENSOR_COUNT = asg_pkg::SENSOR_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [asg_pkg::IN_DATA_W-1:0]    s_tdata,  // sample[9:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// next_channel[2:0] ir_mux_select[6:3] gain_select[8:7] ir_index[12:9]
	// frame_gain[14:13] battery_low[15] boost_ready[16] switch_pos[18:17]
	// left_current[33:19] right_current[48:34]
	output logic [asg_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             m_tlast,  // frame_done
	output logic                             m_tuser,  // ir_sample_valid
	input  logic                             cfg_wr_en,
	input  logic [asg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [asg_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

	asg_pkg::asg_cfg_t    cfg;
	asg_pkg::asg_result_t core_result;
	asg_pkg::asg_result_t out_result;
	logic                 accept;

	assign accept = s_tvalid && s_tready;

	asg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	asg_core #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sample (s_tdata[asg_pkg::SAMPLE_W-1:0]),
		.cfg    (cfg),
		.result (core_result)
	);

	asg_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_result  (core_result),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tdata = {7'b0,
		out_result.right_current,
		out_result.left_current,
		out_result.switch_pos,
		out_result.boost_ready,
		out_result.battery_low,
		out_result.frame_gain,
		out_result.ir_index,
		out_result.gain_select,
		out_result.ir_mux_select,
		out_result.next_channel};
	assign m_tlast = out_result.frame_done;
	assign m_tuser = out_result.ir_sample_valid;

endmodule

@@ verif/testbench.sv @@
module testbench;

	typedef logic [asg_pkg::SAMPLE_W-1:0]  sample_t;
	typedef logic [asg_pkg::IN_DATA_W-1:0] in_data_t;
	typedef logic [asg_pkg::CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [asg_pkg::CFG_DAT_W-1:0] cfg_dat_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [asg_pkg::IN_DATA_W-1:0]  s_tdata;   // sample[9:0]
	logic                           m_tvalid;
	logic                           m_tready;
	// next_channel[2:0] ir_mux_select[6:3] gain_select[8:7] ir_index[12:9]
	// frame_gain[14:13] battery_low[15] boost_ready[16] switch_pos[18:17]
	// left_current[33:19] right_current[48:34]
	logic [asg_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tlast;   // frame_done
	logic                           m_tuser;   // ir_sample_valid
	logic                           cfg_wr_en;
	logic [asg_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [asg_pkg::CFG_DAT_W-1:0]  cfg_wdata;

	adc_scan_sequencer_autogain_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// sequencer state as the testbench sees it
	logic [asg_pkg::CHAN_W-1:0]   seq_chan;
	int                           seq_count;
	logic [asg_pkg::GAIN_W-1:0]   seq_gain;
	logic [asg_pkg::GAIN_W-1:0]   seq_frame_gain;
	logic [asg_pkg::SAMPLE_W-1:0] seq_peak;
	logic [asg_pkg::SAMPLE_W-1:0] rd_boost, rd_battery, rd_left, rd_right, rd_switch;

	// register shadow
	logic [asg_pkg::SAMPLE_W-1:0] thr_gain_hi, thr_gain_lo, thr_battery, thr_boost;
	logic [asg_pkg::SAMPLE_W-1:0] thr_sw_up, thr_sw_lo;
	logic [asg_pkg::SCALE_W-1:0]  cur_scale;

	logic [asg_pkg::CFG_DAT_W-1:0] reg_plan [0:7];

	asg_pkg::asg_result_t due_results [$];
	int                   mismatches;
	int                   burst_left;
	int                   frame_style;
	bit                   rx_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("tb: failure");
		$finish;
	end

	task automatic flag_field(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			if (mismatches < 40)
				$display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
			mismatches++;
		end
	endtask

	function automatic logic [asg_pkg::CURRENT_W-1:0] motor_current(input sample_t rd);
		logic [17:0] prod;
		prod = 18'(rd) * 18'(cur_scale);
		return prod[17:3];
	endfunction

	// one conversion result through the scan sequence
	task automatic advance_sequencer(input sample_t smp);
		asg_pkg::asg_result_t r;
		r = '0;
		case (seq_chan)
			asg_pkg::CH_IR: begin
				r.ir_sample_valid = 1'b1;
				r.ir_index = seq_count[3:0];
				if (smp > seq_peak)
					seq_peak = smp;
				if (seq_count == asg_pkg::SENSOR_COUNT_DEF - 1) begin
					seq_count = 0;
					r.frame_done = 1'b1;
					seq_frame_gain = seq_gain;
					if (seq_peak > thr_gain_hi) begin
						if (seq_gain != '0)
							seq_gain = seq_gain - 1'b1;
					end else if (seq_peak < thr_gain_lo) begin
						if (seq_gain != asg_pkg::GAIN_MAX)
							seq_gain = seq_gain + 1'b1;
					end
					seq_peak = '0;
					seq_chan = asg_pkg::CH_BOOST;
				end else begin
					seq_count++;
					seq_chan = asg_pkg::CH_IR;
				end
			end
			asg_pkg::CH_SWITCH: begin
				rd_switch = smp;
				seq_chan = asg_pkg::CH_IR;
			end
			asg_pkg::CH_RIGHT: begin
				rd_right = smp;
				seq_chan = asg_pkg::CH_SWITCH;
			end
			asg_pkg::CH_LEFT: begin
				rd_left = smp;
				seq_chan = asg_pkg::CH_RIGHT;
			end
			asg_pkg::CH_BATTERY: begin
				rd_battery = smp;
				seq_chan = asg_pkg::CH_LEFT;
			end
			asg_pkg::CH_BOOST: begin
				rd_boost = smp;
				seq_chan = asg_pkg::CH_BATTERY;
			end
			default: begin
				seq_chan = asg_pkg::CH_BOOST;
			end
		endcase
		r.next_channel = seq_chan;
		r.ir_mux_select = seq_count[3:0];
		r.gain_select = seq_gain;
		r.frame_gain = seq_frame_gain;
		r.battery_low = rd_battery < thr_battery;
		r.boost_ready = rd_boost > thr_boost;
		if (rd_switch > thr_sw_up)
			r.switch_pos = asg_pkg::SW_DOWN;
		else if (rd_switch > thr_sw_lo)
			r.switch_pos = asg_pkg::SW_MIDDLE;
		else
			r.switch_pos = asg_pkg::SW_UP;
		r.left_current = motor_current(rd_left);
		r.right_current = motor_current(rd_right);
		due_results.push_back(r);
	endtask

	task automatic send_sample(input sample_t smp);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= in_data_t'(smp);
		do @(posedge clk); while (!s_tready);
		advance_sequencer(smp);
		burst_left--;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_config();
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_wdata <= reg_plan[i];
			@(posedge clk);
			case (cfg_idx_t'(i))
				asg_pkg::REG_GAIN_HIGH: thr_gain_hi = reg_plan[i];
				asg_pkg::REG_GAIN_LOW:  thr_gain_lo = reg_plan[i];
				asg_pkg::REG_BATTERY:   thr_battery = reg_plan[i];
				asg_pkg::REG_BOOST:     thr_boost = reg_plan[i];
				asg_pkg::REG_SW_UPPER:  thr_sw_up = reg_plan[i];
				asg_pkg::REG_SW_LOWER:  thr_sw_lo = reg_plan[i];
				asg_pkg::REG_SCALE:     cur_scale = reg_plan[i][asg_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic sample_t near(input sample_t t);
		int v;
		v = int'(t) + int'($urandom_range(0, 2)) - 1;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return sample_t'(v);
	endfunction

	// samples shaped by the channel that will convert them
	function automatic sample_t pick_sample();
		int roll;
		roll = $urandom_range(0, 7);
		if (seq_chan == asg_pkg::CH_IR) begin
			if (seq_count == 0)
				frame_style = $urandom_range(0, 3);
			case (frame_style)
				0: return sample_t'($urandom_range(0, thr_gain_lo));
				1: return sample_t'($urandom_range(0, 1023));
				2: begin
					if (thr_gain_lo <= thr_gain_hi)
						return sample_t'($urandom_range(thr_gain_lo, thr_gain_hi));
					return sample_t'($urandom_range(0, 1023));
				end
				default: begin
					if (roll == 0)
						return near(thr_gain_hi);
					return near(thr_gain_lo);
				end
			endcase
		end
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		if (roll < 5) begin
			case (seq_chan)
				asg_pkg::CH_BOOST:   return near(thr_boost);
				asg_pkg::CH_BATTERY: return near(thr_battery);
				asg_pkg::CH_SWITCH:  return near(roll[0] ? thr_sw_up : thr_sw_lo);
				default:             return sample_t'($urandom_range(1000, 1023));
			endcase
		end
		return sample_t'($urandom_range(0, 1023));
	endfunction

	task automatic run_random_scan(input int n);
		repeat (n) send_sample(pick_sample());
	endtask

	// a full scan plus the next scan's five non-ir readings right after reset: threshold edges and field extremes
	task automatic test_scan_extremes();
		sample_t pattern [0:25];
		pattern = '{10'd801, 10'd449, 10'd1023, 10'd0, 10'd769,
			10'd0, 10'd1023, 10'd512, 10'd1, 10'd1022, 10'd341, 10'd682, 10'd0,
			10'd1023, 10'd255, 10'd256, 10'd768, 10'd767, 10'd900, 10'd901, 10'd175,
			10'd800, 10'd450, 10'd0, 10'd1023, 10'd256};
		for (int i = 0; i < 26; i++)
			send_sample(pattern[i]);
		settle();
	endtask

	task automatic test_defaults_random();
		run_random_scan(190);
		settle();
	endtask

	task automatic test_config_zero();
		for (int i = 0; i < 6; i++)
			reg_plan[i] = '0;
		reg_plan[asg_pkg::REG_SCALE] = 10'h300;
		reg_plan[7] = 10'h3ff;
		load_config();
		run_random_scan(190);
		settle();
	endtask

	task automatic test_config_max();
		for (int i = 0; i < 7; i++)
			reg_plan[i] = '1;
		reg_plan[7] = 10'h155;
		load_config();
		run_random_scan(190);
		settle();
	endtask

	task automatic test_config_random();
		repeat (2) begin
			for (int i = 0; i < 8; i++)
				reg_plan[i] = cfg_dat_t'($urandom_range(0, 1023));
			load_config();
			run_random_scan(120);
			settle();
		end
	endtask

	task automatic test_backpressure();
		reg_plan[asg_pkg::REG_GAIN_HIGH] = asg_pkg::RST_GAIN_HIGH;
		reg_plan[asg_pkg::REG_GAIN_LOW]  = asg_pkg::RST_GAIN_LOW;
		reg_plan[asg_pkg::REG_BATTERY]   = asg_pkg::RST_BATTERY;
		reg_plan[asg_pkg::REG_BOOST]     = asg_pkg::RST_BOOST;
		reg_plan[asg_pkg::REG_SW_UPPER]  = asg_pkg::RST_SW_UPPER;
		reg_plan[asg_pkg::REG_SW_LOWER]  = asg_pkg::RST_SW_LOWER;
		reg_plan[asg_pkg::REG_SCALE]     = cfg_dat_t'(asg_pkg::RST_SCALE);
		reg_plan[7] = '0;
		load_config();
		rx_hold_req = 1'b1;
		run_random_scan(80);
		settle();
	endtask

	// receiver: stall segments of random style, plus one long hold on request
	initial begin
		int seg_left;
		int seg_mode;
		int phase;
		int hold_left;
		seg_left = 0;
		seg_mode = 0;
		phase = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left = 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_mode = $urandom_range(0, 3);
					seg_left = $urandom_range(4, 60);
				end
				seg_left--;
				phase++;
				case (seg_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (phase % 3) != 0;
					default: m_tready <= $urandom_range(0, 7) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		asg_pkg::asg_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				flag_field("beat with nothing due", 16'd1, 16'd0);
			end else begin
				want = due_results.pop_front();
				flag_field("next_channel", 16'(m_tdata[2:0]), 16'(want.next_channel));
				flag_field("ir_mux_select", 16'(m_tdata[6:3]), 16'(want.ir_mux_select));
				flag_field("gain_select", 16'(m_tdata[8:7]), 16'(want.gain_select));
				flag_field("ir_sample_valid", 16'(m_tuser), 16'(want.ir_sample_valid));
				flag_field("ir_index", 16'(m_tdata[12:9]), 16'(want.ir_index));
				flag_field("frame_done", 16'(m_tlast), 16'(want.frame_done));
				flag_field("frame_gain", 16'(m_tdata[14:13]), 16'(want.frame_gain));
				flag_field("battery_low", 16'(m_tdata[15]), 16'(want.battery_low));
				flag_field("boost_ready", 16'(m_tdata[16]), 16'(want.boost_ready));
				flag_field("switch_pos", 16'(m_tdata[18:17]), 16'(want.switch_pos));
				flag_field("left_current", 16'(m_tdata[33:19]), 16'(want.left_current));
				flag_field("right_current", 16'(m_tdata[48:34]), 16'(want.right_current));
				flag_field("padding", 16'(m_tdata[asg_pkg::OUT_DATA_W-1:49]), 16'd0);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		mismatches = 0;
		burst_left = 0;
		frame_style = 0;
		rx_hold_req = 1'b0;
		seq_chan = asg_pkg::CH_BOOST;
		seq_count = 0;
		seq_gain = '0;
		seq_frame_gain = '0;
		seq_peak = '0;
		rd_boost = '0;
		rd_battery = '0;
		rd_left = '0;
		rd_right = '0;
		rd_switch = '0;
		thr_gain_hi = asg_pkg::RST_GAIN_HIGH;
		thr_gain_lo = asg_pkg::RST_GAIN_LOW;
		thr_battery = asg_pkg::RST_BATTERY;
		thr_boost = asg_pkg::RST_BOOST;
		thr_sw_up = asg_pkg::RST_SW_UPPER;
		thr_sw_lo = asg_pkg::RST_SW_LOWER;
		cur_scale = asg_pkg::RST_SCALE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_scan_extremes();
		test_defaults_random();
		test_config_zero();
		test_config_max();
		test_config_random();
		test_backpressure();

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/asg_pkg.sv
hdl/asg_cfg.sv
hdl/asg_core.sv
hdl/asg_out.sv
hdl/adc_scan_sequencer_autogain_unit.sv
verif/testbench.sv
